// ===== hdl/bsca_pkg.sv =====
// Package for the buddy size-class allocator.
// Holds the transfer payload types, request and status codes, FSM states and
// the command and status structs between controller and datapath. No dependencies.
package bsca_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] heap_sel;
    logic [2:0] other_heap;
    logic [7:0] req_size;
    logic [2:0] load_class;
    logic [7:0] load_count;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] grant_class;
    logic       did_split;
    logic [2:0] split_class;
  } rsp_t;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_MERGE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_BAD_HEAP = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD,
    S_ALLOC_CHK,
    S_ALLOC_USED,
    S_ALLOC_FILL,
    S_FREE_CHK,
    S_MRG_DST,
    S_MRG_SRC,
    S_MRG_WR_DST,
    S_MRG_WR_SRC,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CLS_HOLD,
    CLS_K,
    CLS_ZERO,
    CLS_INC
  } cls_op_t;

  typedef enum logic [1:0] {
    HS_REQ,
    HS_OTHER,
    HS_NEXT
  } heap_src_t;

  typedef enum logic [1:0] {
    CS_WALK,
    CS_K,
    CS_LOAD
  } cls_src_t;

  typedef enum logic [2:0] {
    WV_ZERO,
    WV_ONE,
    WV_LOAD,
    WV_DEC,
    WV_INC,
    WV_INC_HOLD,
    WV_SUM
  } wval_t;

  typedef enum logic [1:0] {
    G_NONE,
    G_LOAD,
    G_K
  } gsel_t;

  typedef struct packed {
    logic      latch_req;
    logic      clr_wr;
    logic      k_load;
    cls_op_t   cls_op;
    logic      scls_load;
    logic      hold;
    heap_src_t rd_heap;
    heap_src_t wr_heap;
    cls_src_t  wr_cls;
    logic      free_wr;
    wval_t     free_val;
    logic      used_wr;
    wval_t     used_val;
    logic      nh_inc;
    logic      res_wr;
    status_t   res_status;
    gsel_t     res_gsel;
    logic      res_split;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    req_kind_t req_type;
    logic      heap_ok;
    logic      merge_ok;
    logic      load_full;
    logic      lcls_ok;
    logic      lcls_last;
    logic      fit_ok;
    logic      exact_ok;
    logic      free_nz;
    logic      used_nz;
    logic      cls_last;
    logic      cls_is_k;
    logic      fill_last;
    logic      clr_last;
  } dp_stat_t;

endpackage

// ===== hdl/buddy_size_class_allocator_core.sv =====
// Buddy size-class allocator: per-heap free and used block counters per
// power-of-two size class, handling load, allocate, free and merge requests.
// One request is processed at a time, one response per request, and a request
// is taken while the previous response still waits in the output register.
// After reset a clearing pass zeroes both counter memories, one entry per cycle,
// over NUM_HEAPS rounded up to a power of two times NUM_CLASSES rounded up to a
// power of two entries (64 with default parameters); no request is taken until
// it is done. Load and any refused request are answered from the decode state;
// free reads and updates the counts of its class; allocate searches upward
// from the fitting class for a free block and, on a split, refills each class
// between the fitting class and the split one; merge walks every class. The
// counter walks go through single read and write ports of the free and used
// count memories. Uses bsca_pkg.
module buddy_size_class_allocator_core #(
  parameter int NUM_HEAPS      = 8,
  parameter int NUM_CLASSES    = 5,
  parameter int MIN_BLOCK_LOG2 = 2,
  parameter int COUNT_WIDTH    = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bsca_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bsca_pkg::rsp_t rsp_data
);

  bsca_pkg::dp_cmd_t  cmd;
  bsca_pkg::dp_stat_t stat;

  bsca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bsca_dp #(
    .NUM_HEAPS      (NUM_HEAPS),
    .NUM_CLASSES    (NUM_CLASSES),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .stat     (stat),
    .rsp_data (rsp_data)
  );

endmodule

// ===== hdl/bsca_ctrl.sv =====
// Controller FSM of the buddy size-class allocator.
// Sequences the counter memory walks and the result register; uses bsca_pkg.
module bsca_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  bsca_pkg::dp_stat_t stat,
  output bsca_pkg::dp_cmd_t  cmd
);

  bsca_pkg::state_t state;
  bsca_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsca_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rd_heap    = bsca_pkg::HS_REQ;
    cmd.wr_heap    = bsca_pkg::HS_REQ;
    cmd.wr_cls     = bsca_pkg::CS_WALK;
    cmd.cls_op     = bsca_pkg::CLS_HOLD;
    cmd.free_val   = bsca_pkg::WV_ZERO;
    cmd.used_val   = bsca_pkg::WV_ZERO;
    cmd.res_status = bsca_pkg::ST_OK;
    cmd.res_gsel   = bsca_pkg::G_NONE;
    req_ready      = 1'b0;
    case (state)
      bsca_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = bsca_pkg::S_IDLE;
        end
      end
      bsca_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = bsca_pkg::S_DECODE;
        end
      end
      bsca_pkg::S_DECODE: begin
        state_next = bsca_pkg::S_DONE;
        cmd.res_wr = 1'b1;
        case (stat.req_type)
          bsca_pkg::REQ_LOAD: begin
            if (stat.load_full) begin
              cmd.res_status = bsca_pkg::ST_BAD_HEAP;
            end else if (!stat.lcls_ok) begin
              cmd.res_status = bsca_pkg::ST_BAD_SIZE;
            end else begin
              cmd.free_wr  = 1'b1;
              cmd.wr_heap  = bsca_pkg::HS_NEXT;
              cmd.wr_cls   = bsca_pkg::CS_LOAD;
              cmd.free_val = bsca_pkg::WV_LOAD;
              cmd.nh_inc   = stat.lcls_last;
              cmd.res_gsel = bsca_pkg::G_LOAD;
            end
          end
          bsca_pkg::REQ_ALLOC: begin
            if (!stat.heap_ok) begin
              cmd.res_status = bsca_pkg::ST_BAD_HEAP;
            end else if (!stat.fit_ok) begin
              cmd.res_status = bsca_pkg::ST_BAD_SIZE;
            end else begin
              cmd.res_wr = 1'b0;
              cmd.k_load = 1'b1;
              cmd.cls_op = bsca_pkg::CLS_K;
              state_next = bsca_pkg::S_RD;
            end
          end
          bsca_pkg::REQ_FREE: begin
            if (!stat.heap_ok) begin
              cmd.res_status = bsca_pkg::ST_BAD_HEAP;
            end else if (!stat.exact_ok) begin
              cmd.res_status = bsca_pkg::ST_BAD_SIZE;
            end else begin
              cmd.res_wr = 1'b0;
              cmd.k_load = 1'b1;
              cmd.cls_op = bsca_pkg::CLS_K;
              state_next = bsca_pkg::S_RD;
            end
          end
          bsca_pkg::REQ_MERGE: begin
            if (!stat.merge_ok) begin
              cmd.res_status = bsca_pkg::ST_BAD_HEAP;
            end else begin
              cmd.res_wr = 1'b0;
              cmd.cls_op = bsca_pkg::CLS_ZERO;
              state_next = bsca_pkg::S_MRG_DST;
            end
          end
          default: ;
        endcase
      end
      bsca_pkg::S_RD: begin
        if (stat.req_type == bsca_pkg::REQ_FREE) begin
          state_next = bsca_pkg::S_FREE_CHK;
        end else begin
          state_next = bsca_pkg::S_ALLOC_CHK;
        end
      end
      bsca_pkg::S_ALLOC_CHK: begin
        cmd.hold = stat.cls_is_k;
        if (stat.free_nz) begin
          cmd.free_wr   = 1'b1;
          cmd.free_val  = bsca_pkg::WV_DEC;
          cmd.scls_load = 1'b1;
          cmd.res_wr    = 1'b1;
          cmd.res_gsel  = bsca_pkg::G_K;
          cmd.res_split = !stat.cls_is_k;
          state_next    = bsca_pkg::S_ALLOC_USED;
        end else if (stat.cls_last) begin
          cmd.res_wr     = 1'b1;
          cmd.res_status = bsca_pkg::ST_NO_FREE;
          cmd.res_gsel   = bsca_pkg::G_K;
          state_next     = bsca_pkg::S_DONE;
        end else begin
          cmd.cls_op = bsca_pkg::CLS_INC;
          state_next = bsca_pkg::S_RD;
        end
      end
      bsca_pkg::S_ALLOC_USED: begin
        cmd.used_wr  = 1'b1;
        cmd.wr_cls   = bsca_pkg::CS_K;
        cmd.used_val = bsca_pkg::WV_INC_HOLD;
        if (stat.cls_is_k) begin
          state_next = bsca_pkg::S_DONE;
        end else begin
          cmd.cls_op = bsca_pkg::CLS_K;
          state_next = bsca_pkg::S_ALLOC_FILL;
        end
      end
      bsca_pkg::S_ALLOC_FILL: begin
        cmd.free_wr  = 1'b1;
        cmd.free_val = bsca_pkg::WV_ONE;
        if (stat.fill_last) begin
          state_next = bsca_pkg::S_DONE;
        end else begin
          cmd.cls_op = bsca_pkg::CLS_INC;
        end
      end
      bsca_pkg::S_FREE_CHK: begin
        cmd.res_wr   = 1'b1;
        cmd.res_gsel = bsca_pkg::G_K;
        state_next   = bsca_pkg::S_DONE;
        if (!stat.used_nz) begin
          cmd.res_status = bsca_pkg::ST_BAD_SIZE;
        end else begin
          cmd.used_wr  = 1'b1;
          cmd.used_val = bsca_pkg::WV_DEC;
          cmd.free_wr  = 1'b1;
          cmd.free_val = bsca_pkg::WV_INC;
        end
      end
      bsca_pkg::S_MRG_DST: begin
        state_next = bsca_pkg::S_MRG_SRC;
      end
      bsca_pkg::S_MRG_SRC: begin
        cmd.rd_heap = bsca_pkg::HS_OTHER;
        cmd.hold    = 1'b1;
        state_next  = bsca_pkg::S_MRG_WR_DST;
      end
      bsca_pkg::S_MRG_WR_DST: begin
        cmd.free_wr  = 1'b1;
        cmd.used_wr  = 1'b1;
        cmd.free_val = bsca_pkg::WV_SUM;
        cmd.used_val = bsca_pkg::WV_SUM;
        state_next   = bsca_pkg::S_MRG_WR_SRC;
      end
      bsca_pkg::S_MRG_WR_SRC: begin
        cmd.free_wr = 1'b1;
        cmd.used_wr = 1'b1;
        cmd.wr_heap = bsca_pkg::HS_OTHER;
        if (stat.cls_last) begin
          cmd.res_wr = 1'b1;
          state_next = bsca_pkg::S_DONE;
        end else begin
          cmd.cls_op = bsca_pkg::CLS_INC;
          state_next = bsca_pkg::S_MRG_DST;
        end
      end
      bsca_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = bsca_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bsca_pkg::S_IDLE;
      end
    endcase
  end

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while occupied");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == bsca_pkg::S_DONE)
    else $error("result raised outside completion");

  a_free_dec_nz: assert property (@(posedge clk) disable iff (rst)
    (cmd.free_wr && cmd.free_val == bsca_pkg::WV_DEC) |-> stat.free_nz)
    else $error("free count decremented at zero");

endmodule

// ===== hdl/bsca_dp.sv =====
// Datapath of the buddy size-class allocator.
// Free and used counter memories, class walk registers, heap bookkeeping and
// the result register; driven by bsca_ctrl commands, uses bsca_pkg.
module bsca_dp #(
  parameter int NUM_HEAPS      = 8,
  parameter int NUM_CLASSES    = 5,
  parameter int MIN_BLOCK_LOG2 = 2,
  parameter int COUNT_WIDTH    = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  bsca_pkg::req_t     req_data,
  input  bsca_pkg::dp_cmd_t  cmd,
  output bsca_pkg::dp_stat_t stat,
  output bsca_pkg::rsp_t     rsp_data
);

  localparam int NHW   = $clog2(NUM_HEAPS + 1);
  localparam int HW    = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1;
  localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int AW    = HW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int IXW   = (NHW > 3) ? NHW : 3;

  bsca_pkg::req_t         req;
  bsca_pkg::rsp_t         wres;
  logic [NHW-1:0]         next_heap;
  logic [AW-1:0]          clr_cnt;
  logic [CW-1:0]          cls;
  logic [CW-1:0]          kcls;
  logic [CW-1:0]          scls;
  logic [COUNT_WIDTH-1:0] hold_free;
  logic [COUNT_WIDTH-1:0] hold_used;
  logic [COUNT_WIDTH-1:0] free_q;
  logic [COUNT_WIDTH-1:0] used_q;
  logic [COUNT_WIDTH-1:0] free_mem [DEPTH];
  logic [COUNT_WIDTH-1:0] used_mem [DEPTH];

  logic [IXW-1:0]         hs_ix;
  logic [IXW-1:0]         ho_ix;
  logic [IXW-1:0]         nh_ix;
  logic [4:0]             lcls5;
  logic [31:0]            size32;
  logic [32:0]            lcnt33;
  logic [COUNT_WIDTH-1:0] lcnt_sat;
  logic                   fit_ok;
  logic                   exact_ok;
  logic [CW-1:0]          fit_k;
  logic [CW-1:0]          exact_k;
  logic [HW-1:0]          rheap;
  logic [HW-1:0]          wheap;
  logic [CW-1:0]          wcls;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic                   free_we;
  logic                   used_we;
  logic [COUNT_WIDTH-1:0] free_wdata;
  logic [COUNT_WIDTH-1:0] used_wdata;
  logic [2:0]             gcls;

  function automatic logic [COUNT_WIDTH-1:0] wval(
    input bsca_pkg::wval_t        op,
    input logic [COUNT_WIDTH-1:0] q,
    input logic [COUNT_WIDTH-1:0] hold,
    input logic [COUNT_WIDTH-1:0] load
  );
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] v;
    sum = {1'b0, hold} + {1'b0, q};
    case (op)
      bsca_pkg::WV_ZERO:     v = '0;
      bsca_pkg::WV_ONE:      v = COUNT_WIDTH'(1);
      bsca_pkg::WV_LOAD:     v = load;
      bsca_pkg::WV_DEC:      v = q - COUNT_WIDTH'(1);
      bsca_pkg::WV_INC:      v = (&q) ? q : q + COUNT_WIDTH'(1);
      bsca_pkg::WV_INC_HOLD: v = (&hold) ? hold : hold + COUNT_WIDTH'(1);
      bsca_pkg::WV_SUM:      v = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
      default:               v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    hs_ix  = IXW'(req.heap_sel);
    ho_ix  = IXW'(req.other_heap);
    nh_ix  = IXW'(next_heap);
    lcls5  = 5'(req.load_class);
    size32 = 32'(req.req_size);
    lcnt33 = 33'(req.load_count);
    lcnt_sat = (lcnt33 > ((33'd1 << COUNT_WIDTH) - 33'd1)) ? '1
                                                          : COUNT_WIDTH'(req.load_count);
  end

  always_comb begin
    fit_ok   = 1'b0;
    exact_ok = 1'b0;
    fit_k    = '0;
    exact_k  = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!fit_ok && (size32 <= (32'd1 << (MIN_BLOCK_LOG2 + c)))) begin
        fit_ok = 1'b1;
        fit_k  = CW'(c);
      end
      if (size32 == (32'd1 << (MIN_BLOCK_LOG2 + c))) begin
        exact_ok = 1'b1;
        exact_k  = CW'(c);
      end
    end
  end

  always_comb begin
    case (cmd.rd_heap)
      bsca_pkg::HS_OTHER: rheap = ho_ix[HW-1:0];
      bsca_pkg::HS_NEXT:  rheap = nh_ix[HW-1:0];
      default:            rheap = hs_ix[HW-1:0];
    endcase
    case (cmd.wr_heap)
      bsca_pkg::HS_OTHER: wheap = ho_ix[HW-1:0];
      bsca_pkg::HS_NEXT:  wheap = nh_ix[HW-1:0];
      default:            wheap = hs_ix[HW-1:0];
    endcase
    case (cmd.wr_cls)
      bsca_pkg::CS_K:    wcls = kcls;
      bsca_pkg::CS_LOAD: wcls = lcls5[CW-1:0];
      default:           wcls = cls;
    endcase
    raddr      = {rheap, cls};
    waddr      = cmd.clr_wr ? clr_cnt : {wheap, wcls};
    free_we    = cmd.free_wr || cmd.clr_wr;
    used_we    = cmd.used_wr || cmd.clr_wr;
    free_wdata = cmd.clr_wr ? '0 : wval(cmd.free_val, free_q, hold_free, lcnt_sat);
    used_wdata = cmd.clr_wr ? '0 : wval(cmd.used_val, used_q, hold_used, lcnt_sat);
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[waddr] <= free_wdata;
    end
    free_q <= free_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[waddr] <= used_wdata;
    end
    used_q <= used_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_heap <= '0;
      clr_cnt   <= '0;
    end else begin
      if (cmd.nh_inc) begin
        next_heap <= next_heap + NHW'(1);
      end
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req <= req_data;
    end
    if (cmd.k_load) begin
      kcls <= (req.req_type == bsca_pkg::REQ_FREE) ? exact_k : fit_k;
    end
    case (cmd.cls_op)
      bsca_pkg::CLS_K:    cls <= (req.req_type == bsca_pkg::REQ_FREE) ? exact_k
                                 : (cmd.k_load ? fit_k : kcls);
      bsca_pkg::CLS_ZERO: cls <= '0;
      bsca_pkg::CLS_INC:  cls <= cls + CW'(1);
      default:            cls <= cls;
    endcase
    if (cmd.scls_load) begin
      scls <= cls;
    end
    if (cmd.hold) begin
      hold_free <= free_q;
      hold_used <= used_q;
    end
  end

  always_comb begin
    case (cmd.res_gsel)
      bsca_pkg::G_LOAD: gcls = req.load_class;
      bsca_pkg::G_K:    gcls = 3'(kcls);
      default:          gcls = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      wres.status      <= cmd.res_status;
      wres.grant_class <= gcls;
      wres.did_split   <= cmd.res_split;
      wres.split_class <= cmd.res_split ? 3'(cls) : 3'd0;
    end
    if (cmd.out_load) begin
      rsp_data <= wres;
    end
  end

  always_comb begin
    stat.req_type  = bsca_pkg::req_kind_t'(req.req_type);
    stat.heap_ok   = hs_ix < nh_ix;
    stat.merge_ok  = (hs_ix < nh_ix) && (ho_ix < nh_ix) && (req.heap_sel != req.other_heap);
    stat.load_full = next_heap >= NHW'(NUM_HEAPS);
    stat.lcls_ok   = lcls5 < 5'(NUM_CLASSES);
    stat.lcls_last = lcls5 == 5'(NUM_CLASSES - 1);
    stat.fit_ok    = fit_ok;
    stat.exact_ok  = exact_ok;
    stat.free_nz   = free_q != '0;
    stat.used_nz   = used_q != '0;
    stat.cls_last  = cls == CW'(NUM_CLASSES - 1);
    stat.cls_is_k  = cls == kcls;
    stat.fill_last = ({1'b0, cls} + (CW + 1)'(1)) == {1'b0, scls};
    stat.clr_last  = &clr_cnt;
  end

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    next_heap <= NHW'(NUM_HEAPS))
    else $error("heap creation ran past the last heap");

  a_fill_below_split: assert property (@(posedge clk) disable iff (rst)
    (cmd.free_wr && cmd.free_val == bsca_pkg::WV_ONE) |-> (cls < scls && cls >= kcls))
    else $error("split fill outside the split range");

  a_used_dec_nz: assert property (@(posedge clk) disable iff (rst)
    (cmd.used_wr && cmd.used_val == bsca_pkg::WV_DEC) |-> used_q != '0)
    else $error("used count decremented at zero");

endmodule

// ===== sim/tb_buddy_size_class_allocator_core.sv =====
// Self-checking bench for buddy_size_class_allocator_core: a heap ledger class
// predicts every response from accepted requests and checks the response stream.
// Depends on bsca_pkg and the core RTL only.
`timescale 1ns / 100ps

localparam int HEAPS     = 8;
localparam int CLASSES   = 5;
localparam int MIN_LOG2  = 2;
localparam int CNT_MAX   = 255;
localparam int LONG_HOLD = 400;
localparam int LIMIT     = 600000;

class buddy_ledger;
  logic [7:0]     free_cnt [HEAPS][CLASSES];
  logic [7:0]     used_cnt [HEAPS][CLASSES];
  int             heaps_made;
  bsca_pkg::rsp_t pending_rsp[$];
  int             errors;
  int             status_hits[4];
  int             split_hits;

  function new();
    foreach (free_cnt[h, k]) begin
      free_cnt[h][k] = '0;
      used_cnt[h][k] = '0;
    end
    heaps_made = 0;
    errors = 0;
    split_hits = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
  endfunction

  function logic [7:0] bump(logic [7:0] v);
    return (v == 8'(CNT_MAX)) ? v : v + 8'd1;
  endfunction

  function logic [7:0] sat_sum(logic [7:0] a, logic [7:0] b);
    return ((int'(a) + int'(b)) > CNT_MAX) ? 8'(CNT_MAX) : a + b;
  endfunction

  // Apply one accepted request to the ledger and queue its response.
  function void log_request(bsca_pkg::req_t r);
    bsca_pkg::rsp_t e;
    int   h, o, k, j, m;
    e = '0;
    h = int'(r.heap_sel);
    o = int'(r.other_heap);
    case (r.req_type)
      bsca_pkg::REQ_LOAD: begin
        if (heaps_made >= HEAPS) e.status = bsca_pkg::ST_BAD_HEAP;
        else if (int'(r.load_class) >= CLASSES) e.status = bsca_pkg::ST_BAD_SIZE;
        else begin
          free_cnt[heaps_made][r.load_class] = r.load_count;
          e.grant_class = r.load_class;
          if (int'(r.load_class) == CLASSES - 1) heaps_made++;
        end
      end
      bsca_pkg::REQ_ALLOC: begin
        if (h >= heaps_made) e.status = bsca_pkg::ST_BAD_HEAP;
        else begin
          k = 0;
          while (k < CLASSES && (1 << (MIN_LOG2 + k)) < int'(r.req_size)) k++;
          if (k == CLASSES) e.status = bsca_pkg::ST_BAD_SIZE;
          else begin
            e.grant_class = 3'(k);
            if (free_cnt[h][k] != 0) begin
              free_cnt[h][k] = free_cnt[h][k] - 8'd1;
              used_cnt[h][k] = bump(used_cnt[h][k]);
            end else begin
              j = k + 1;
              while (j < CLASSES && free_cnt[h][j] == 0) j++;
              if (j == CLASSES) e.status = bsca_pkg::ST_NO_FREE;
              else begin
                free_cnt[h][j] = free_cnt[h][j] - 8'd1;
                for (m = k; m < j; m++) free_cnt[h][m] = bump(free_cnt[h][m]);
                used_cnt[h][k] = bump(used_cnt[h][k]);
                e.did_split = 1'b1;
                e.split_class = 3'(j);
              end
            end
          end
        end
      end
      bsca_pkg::REQ_FREE: begin
        if (h >= heaps_made) e.status = bsca_pkg::ST_BAD_HEAP;
        else begin
          k = 0;
          while (k < CLASSES && (1 << (MIN_LOG2 + k)) != int'(r.req_size)) k++;
          if (k == CLASSES) e.status = bsca_pkg::ST_BAD_SIZE;
          else begin
            e.grant_class = 3'(k);
            if (used_cnt[h][k] == 0) e.status = bsca_pkg::ST_BAD_SIZE;
            else begin
              used_cnt[h][k] = used_cnt[h][k] - 8'd1;
              free_cnt[h][k] = bump(free_cnt[h][k]);
            end
          end
        end
      end
      default: begin
        if (h >= heaps_made || o >= heaps_made || h == o) e.status = bsca_pkg::ST_BAD_HEAP;
        else begin
          for (k = 0; k < CLASSES; k++) begin
            free_cnt[h][k] = sat_sum(free_cnt[h][k], free_cnt[o][k]);
            used_cnt[h][k] = sat_sum(used_cnt[h][k], used_cnt[o][k]);
            free_cnt[o][k] = '0;
            used_cnt[o][k] = '0;
          end
        end
      end
    endcase
    pending_rsp.push_back(e);
  endfunction

  function void cmp(string fname, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      errors++;
    end
  endfunction

  function void check_response(bsca_pkg::rsp_t got);
    bsca_pkg::rsp_t e;
    if (pending_rsp.size() == 0) begin
      $error("response with no request outstanding: %p", got);
      errors++;
      return;
    end
    e = pending_rsp.pop_front();
    cmp("status", 8'(e.status), 8'(got.status));
    cmp("grant_class", 8'(e.grant_class), 8'(got.grant_class));
    cmp("did_split", 8'(e.did_split), 8'(got.did_split));
    cmp("split_class", 8'(e.split_class), 8'(got.split_class));
    status_hits[e.status]++;
    if (e.did_split) split_hits++;
  endfunction
endclass

module tb_buddy_size_class_allocator_core;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  bsca_pkg::req_t req_data = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  bsca_pkg::rsp_t rsp_data;

  buddy_ledger ledger = new();
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          holds_asked = 0;
  int          cycle_cnt = 0;

  buddy_size_class_allocator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_buddy_size_class_allocator_core failed");
      $finish;
    end
  end

  // Response side: check each transfer, stall in random bursts or on request.
  initial begin : rsp_side
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) ledger.check_response(rsp_data);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic send_req(input bsca_pkg::req_t r);
    req_data <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    ledger.log_request(r);
  endtask

  task automatic tx_gap();
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic bsca_pkg::req_t make_req(bsca_pkg::req_kind_t kind, int h, int o,
                                              int sz, int lc, int cnt);
    bsca_pkg::req_t r;
    r.req_type   = kind;
    r.heap_sel   = 3'(h);
    r.other_heap = 3'(o);
    r.req_size   = 8'(sz);
    r.load_class = 3'(lc);
    r.load_count = 8'(cnt);
    return r;
  endfunction

  function automatic bsca_pkg::req_t random_request();
    bsca_pkg::req_t r;
    int   act, roll, k, n, h;
    r.req_type   = 2'($urandom_range(0, 3));
    r.heap_sel   = 3'($urandom_range(0, 7));
    r.other_heap = 3'($urandom_range(0, 7));
    r.req_size   = 8'($urandom_range(0, 255));
    r.load_class = 3'($urandom_range(0, 7));
    r.load_count = 8'($urandom_range(0, 255));
    act = ledger.heaps_made;
    roll = $urandom_range(0, 99);
    if (roll < 8) return r;
    h = (act > 0 && $urandom_range(0, 9) != 0) ? int'($urandom_range(0, act - 1))
                                                : int'(r.heap_sel);
    r.heap_sel = 3'(h);
    if (roll < 14) begin
      r.req_type = bsca_pkg::REQ_LOAD;
      r.load_class = ($urandom_range(0, 4) == 0) ? 3'(CLASSES - 1)
                                                 : 3'($urandom_range(0, CLASSES - 2));
      if ($urandom_range(0, 3) != 0) r.load_count = 8'($urandom_range(0, 40));
    end else if (roll < 55) begin
      r.req_type = bsca_pkg::REQ_ALLOC;
      if ($urandom_range(0, 6) != 0) begin
        k = $urandom_range(0, CLASSES - 1);
        r.req_size = (k == 0) ? 8'($urandom_range(0, 4))
                              : 8'($urandom_range((2 << k) + 1, 4 << k));
      end
    end else if (roll < 88) begin
      r.req_type = bsca_pkg::REQ_FREE;
      if ($urandom_range(0, 6) != 0) begin
        k = $urandom_range(0, CLASSES - 1);
        for (n = 0; n < CLASSES && ledger.used_cnt[h][k] == 0; n++) k = (k + 1) % CLASSES;
        r.req_size = 8'(1 << (MIN_LOG2 + k));
      end
    end else begin
      r.req_type = bsca_pkg::REQ_MERGE;
      if (act > 0 && $urandom_range(0, 4) != 0) r.other_heap = 3'($urandom_range(0, act - 1));
    end
    return r;
  endfunction

  initial begin : req_side
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_req(make_req(bsca_pkg::REQ_ALLOC, 0, 0, 4, 0, 0));
    send_req(make_req(bsca_pkg::REQ_MERGE, 1, 0, 0, 0, 0));
    send_req(make_req(bsca_pkg::REQ_LOAD, 0, 0, 0, 7, 255));
    send_req(make_req(bsca_pkg::REQ_LOAD, 0, 0, 0, 5, 1));
    send_req(make_req(bsca_pkg::REQ_LOAD, 0, 0, 0, 0, 255));
    send_req(make_req(bsca_pkg::REQ_LOAD, 0, 0, 0, 1, 0));
    send_req(make_req(bsca_pkg::REQ_LOAD, 0, 0, 0, 2, 1));
    send_req(make_req(bsca_pkg::REQ_LOAD, 0, 0, 0, 3, 0));
    send_req(make_req(bsca_pkg::REQ_LOAD, 0, 0, 0, 4, 2));
    send_req(make_req(bsca_pkg::REQ_ALLOC, 0, 0, 0, 0, 0));
    send_req(make_req(bsca_pkg::REQ_ALLOC, 0, 0, 255, 0, 0));
    send_req(make_req(bsca_pkg::REQ_ALLOC, 0, 0, 64, 0, 0));
    send_req(make_req(bsca_pkg::REQ_ALLOC, 0, 0, 5, 0, 0));
    send_req(make_req(bsca_pkg::REQ_ALLOC, 0, 0, 17, 0, 0));
    send_req(make_req(bsca_pkg::REQ_FREE, 0, 0, 7, 0, 0));
    send_req(make_req(bsca_pkg::REQ_FREE, 0, 0, 16, 0, 0));
    send_req(make_req(bsca_pkg::REQ_FREE, 0, 0, 4, 0, 0));
    send_req(make_req(bsca_pkg::REQ_ALLOC, 0, 0, 3, 0, 0));
    send_req(make_req(bsca_pkg::REQ_MERGE, 0, 0, 0, 0, 0));
    send_req(make_req(bsca_pkg::REQ_MERGE, 0, 1, 0, 0, 0));
    send_req(make_req(bsca_pkg::REQ_LOAD, 0, 0, 0, 0, 255));
    send_req(make_req(bsca_pkg::REQ_LOAD, 0, 0, 0, 4, 255));
    send_req(make_req(bsca_pkg::REQ_MERGE, 0, 1, 0, 0, 0));
    send_req(make_req(bsca_pkg::REQ_FREE, 0, 0, 4, 0, 0));
    send_req(make_req(bsca_pkg::REQ_ALLOC, 1, 0, 32, 0, 0));
    send_req(make_req(bsca_pkg::REQ_ALLOC, 7, 0, 8, 0, 0));
    send_req(make_req(bsca_pkg::REQ_MERGE, 7, 7, 0, 0, 0));
    drain();

    // Exhaust the smallest class of heap 0 so its used count saturates.
    for (i = 0; i < 260; i++) begin
      tx_gap();
      send_req(make_req(bsca_pkg::REQ_ALLOC, 0, 0, 4, 0, 0));
    end

    for (i = 0; i < 1060; i++) begin
      if (i % 100 == 0) begin
        tx_idle_en = $urandom_range(0, 2) != 0;
        rx_idle_en = $urandom_range(0, 2) != 0;
      end
      if (i >= 910) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (i == 250) holds_asked++;
      if (i == 550) drain();
      tx_gap();
      send_req(random_request());
    end

    req_valid <= 1'b0;
    while (ledger.pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d responses: ok %0d, no block %0d, bad size %0d, bad heap %0d",
             ledger.status_hits[0] + ledger.status_hits[1] + ledger.status_hits[2] +
             ledger.status_hits[3], ledger.status_hits[0], ledger.status_hits[1],
             ledger.status_hits[2], ledger.status_hits[3]);
    $display("%0d allocations split a larger block, %0d heaps created",
             ledger.split_hits, ledger.heaps_made);
    if (ledger.errors == 0 && ledger.pending_rsp.size() == 0) begin
      $display("tb_buddy_size_class_allocator_core passed");
    end else begin
      $display("tb_buddy_size_class_allocator_core failed");
    end
    $finish;
  end

endmodule
